// ----- src/baro_pressure_temp_compensation_macros.svh -----
// Assertion macros shared by the barometer compensation RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_MACROS_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BPTC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BPTC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/bptc_pkg.sv -----
// Types and constants for the barometer compensation pipeline.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bptc_pkg;

  localparam int CAL_W   = 16;
  localparam int RAW_W   = 24;
  localparam int DT_W    = 25;
  localparam int ACC_W   = 40;  // offset and sensitivity after all corrections
  localparam int TEMP_W  = 20;
  localparam int TCORR_W = 18;
  localparam int PRES_W  = 32;
  localparam int IDX_W   = 3;

  localparam int PIPE_DEPTH = 9;

  localparam logic [IDX_W-1:0] REG_PRESSURE_SENSITIVITY   = 3'd0;
  localparam logic [IDX_W-1:0] REG_PRESSURE_OFFSET        = 3'd1;
  localparam logic [IDX_W-1:0] REG_SENSITIVITY_TEMP_COEFF = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFFSET_TEMP_COEFF      = 3'd3;
  localparam logic [IDX_W-1:0] REG_REFERENCE_TEMPERATURE  = 3'd4;
  localparam logic [IDX_W-1:0] REG_TEMPERATURE_COEFF      = 3'd5;

  localparam logic signed [TEMP_W-1:0] TEMP_REF = 20'sd2000;
  localparam logic signed [TEMP_W-1:0] COLD_REF = -20'sd1500;
  localparam logic signed [TEMP_W-1:0] COLD_OFS = 20'sd1500;

  typedef struct packed {
    logic [CAL_W-1:0] pressure_sensitivity;
    logic [CAL_W-1:0] pressure_offset;
    logic [CAL_W-1:0] sensitivity_temp_coeff;
    logic [CAL_W-1:0] offset_temp_coeff;
    logic [CAL_W-1:0] reference_temperature;
    logic [CAL_W-1:0] temperature_coeff;
  } cal_t;

  // First-order results plus the pending temperature correction
  typedef struct packed {
    logic        [RAW_W-1:0]   raw_pressure;
    logic signed [ACC_W-1:0]   offset;
    logic signed [ACC_W-1:0]   sensitivity;
    logic signed [TEMP_W-1:0]  temperature;
    logic        [TCORR_W-1:0] temp_corr;
  } front_t;

  // Fully corrected terms ready for the pressure product
  typedef struct packed {
    logic        [RAW_W-1:0]  raw_pressure;
    logic signed [ACC_W-1:0]  offset;
    logic signed [ACC_W-1:0]  sensitivity;
    logic signed [TEMP_W-1:0] temperature;
  } corr_t;

endpackage

`default_nettype wire

// ----- src/bptc_front.sv -----
// First-order stages: temperature difference, calibration products, offset,
// sensitivity and temperature. Depends on bptc_pkg.
`default_nettype none

module bptc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bptc_pkg::cal_t    cal,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [23:0]       in_raw_pressure,
  input  wire logic [23:0]       in_raw_temperature,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bptc_pkg::front_t       out_data
);

  logic v1, v2, v3;
  logic en1, en2, en3;

  // stage 1
  logic        [bptc_pkg::RAW_W-1:0] d1_1;
  logic signed [bptc_pkg::DT_W-1:0]  dt1;
  logic signed [bptc_pkg::DT_W-1:0]  dt_c;

  // stage 2
  logic        [bptc_pkg::RAW_W-1:0] d1_2;
  logic signed [41:0]                moff2, msens2, mt2;
  logic signed [49:0]                mdd2;
  logic signed [41:0]                moff_c, msens_c, mt_c;
  logic signed [49:0]                mdd_c;

  // stage 3 inputs
  logic signed [41:0]                off_sh_c, sens_sh_c, t_sh_c;
  bptc_pkg::front_t                  res_c;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign out_valid = v3;

  always_comb begin
    dt_c = $signed({1'b0, in_raw_temperature}) -
           $signed({1'b0, cal.reference_temperature, 8'h00});
  end

  always_comb begin
    moff_c  = $signed({1'b0, cal.offset_temp_coeff}) * dt1;
    msens_c = $signed({1'b0, cal.sensitivity_temp_coeff}) * dt1;
    mt_c    = $signed({1'b0, cal.temperature_coeff}) * dt1;
    mdd_c   = dt1 * dt1;
  end

  always_comb begin
    off_sh_c  = moff2 >>> 7;
    sens_sh_c = msens2 >>> 8;
    t_sh_c    = mt2 >>> 23;
    res_c.raw_pressure = d1_2;
    res_c.offset       = {8'h00, cal.pressure_offset, 16'h0000} + off_sh_c[39:0];
    res_c.sensitivity  = {9'h000, cal.pressure_sensitivity, 15'h0000} + sens_sh_c[39:0];
    res_c.temperature  = bptc_pkg::TEMP_REF + t_sh_c[19:0];
    // the square is never negative: drop the sign bit with the shift
    res_c.temp_corr    = mdd2[48:31];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      d1_1 <= in_raw_pressure;
      dt1  <= dt_c;
    end
    if (en2) begin
      d1_2   <= d1_1;
      moff2  <= moff_c;
      msens2 <= msens_c;
      mt2    <= mt_c;
      mdd2   <= mdd_c;
    end
    if (en3) begin
      out_data <= res_c;
    end
  end

endmodule

`default_nettype wire

// ----- src/bptc_corr.sv -----
// Second-order stages: low and very-low temperature corrections to offset,
// sensitivity and temperature. Depends on bptc_pkg and the macros header.
`default_nettype none
`include "baro_pressure_temp_compensation_macros.svh"

module bptc_corr (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bptc_pkg::front_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bptc_pkg::corr_t        out_data
);

  logic v4, v5, v6;
  logic en4, en5, en6;

  // stage 4
  bptc_pkg::front_t                   f4;
  logic                               low4, cold4;
  logic        [bptc_pkg::ACC_W-1:0]  dsq4, esq4;
  logic signed [bptc_pkg::TEMP_W-1:0] dm_c, em_c;
  logic signed [bptc_pkg::ACC_W-1:0]  dsq_c, esq_c;

  // stage 5
  bptc_pkg::front_t                   f5;
  logic                               low5;
  logic        [bptc_pkg::ACC_W-1:0]  d5, e7_5, e11h5;
  logic        [bptc_pkg::ACC_W-1:0]  d5_c, e7_c, e11_c;

  bptc_pkg::corr_t                    res_c;

  assign en6       = !v6 || out_ready;
  assign en5       = !v5 || en6;
  assign en4       = !v4 || en5;
  assign in_ready  = en4;
  assign out_valid = v6;

  always_comb begin
    dm_c  = in_data.temperature - bptc_pkg::TEMP_REF;
    em_c  = in_data.temperature + bptc_pkg::COLD_OFS;
    dsq_c = dm_c * dm_c;
    esq_c = em_c * em_c;
  end

  always_comb begin
    d5_c  = (dsq4 << 2) + dsq4;
    e7_c  = (esq4 << 3) - esq4;
    e11_c = (esq4 << 3) + (esq4 << 1) + esq4;
  end

  always_comb begin
    res_c.raw_pressure = f5.raw_pressure;
    res_c.offset       = f5.offset - {1'b0, d5[39:1]} - e7_5;
    res_c.sensitivity  = f5.sensitivity - {2'b00, d5[39:2]} - e11h5;
    res_c.temperature  = low5 ? f5.temperature - {2'b00, f5.temp_corr}
                              : f5.temperature;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en4) v4 <= in_valid;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      f4    <= in_data;
      low4  <= in_data.temperature < bptc_pkg::TEMP_REF;
      cold4 <= in_data.temperature < bptc_pkg::COLD_REF;
      dsq4  <= dsq_c;
      esq4  <= esq_c;
    end
    if (en5) begin
      f5    <= f4;
      low5  <= low4;
      // zero the terms of corrections that do not apply
      d5    <= low4  ? d5_c : '0;
      e7_5  <= cold4 ? e7_c : '0;
      e11h5 <= cold4 ? {1'b0, e11_c[39:1]} : '0;
    end
    if (en6) begin
      out_data <= res_c;
    end
  end

  `BPTC_ASSERT_IMP(a_cold_is_low, clk, rst, v4 && cold4, low4, "cold flag without low flag")
  `BPTC_ASSERT_NXT(a_low_matches_temp, clk, rst, v5 && en6, (out_data.temperature < bptc_pkg::TEMP_REF) == $past(low5), "corrected temperature disagrees with low flag")
  `BPTC_ASSERT_NXT(a_warm_untouched, clk, rst, v5 && en6 && !low5, (out_data.offset == $past(f5.offset)) && (out_data.sensitivity == $past(f5.sensitivity)), "warm beat was corrected")

endmodule

`default_nettype wire

// ----- src/bptc_press.sv -----
// Pressure stages: split 24x40 product, recombination, offset subtract and
// final shift into the output register. Depends on bptc_pkg.
`default_nettype none

module bptc_press (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bptc_pkg::corr_t   in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [31:0]            out_pressure,
  output logic [19:0]            out_temperature
);

  logic v7, v8, v9;
  logic en7, en8, en9;

  // stage 7
  logic        [43:0]                 pp_lo7;
  logic signed [44:0]                 pp_hi7;
  logic signed [bptc_pkg::ACC_W-1:0]  off7;
  logic        [bptc_pkg::TEMP_W-1:0] temp7;
  logic        [43:0]                 pp_lo_c;
  logic signed [44:0]                 pp_hi_c;

  // stage 8
  logic signed [63:0]                 prod8;
  logic signed [bptc_pkg::ACC_W-1:0]  off8;
  logic        [bptc_pkg::TEMP_W-1:0] temp8;

  logic signed [63:0]                 prod_sh_c;
  logic        [47:0]                 q_c;

  assign en9       = !v9 || out_ready;
  assign en8       = !v8 || en9;
  assign en7       = !v7 || en8;
  assign in_ready  = en7;
  assign out_valid = v9;

  // low half unsigned, high half carries the sign
  always_comb begin
    pp_lo_c = in_data.raw_pressure * in_data.sensitivity[19:0];
    pp_hi_c = $signed({1'b0, in_data.raw_pressure}) * $signed(in_data.sensitivity[39:20]);
  end

  always_comb begin
    prod_sh_c = prod8 >>> 21;
    q_c       = prod_sh_c[47:0] - {{8{off8[39]}}, off8};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else begin
      if (en7) v7 <= in_valid;
      if (en8) v8 <= v7;
      if (en9) v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en7) begin
      pp_lo7 <= pp_lo_c;
      pp_hi7 <= pp_hi_c;
      off7   <= in_data.offset;
      temp7  <= in_data.temperature;
    end
    if (en8) begin
      prod8 <= {pp_hi7[43:0], 20'h00000} + {20'h00000, pp_lo7};
      off8  <= off7;
      temp8 <= temp7;
    end
    if (en9) begin
      out_pressure    <= q_c[46:15];
      out_temperature <= temp8;
    end
  end

endmodule

`default_nettype wire

// ----- src/baro_pressure_temp_compensation.sv -----
// Barometer compensation: takes one raw pressure/temperature pair per beat and
// returns compensated pressure (0.01 mbar, low 32 bits) and temperature (0.01
// degC). A fully registered nine-stage pipeline accepts a new pair every cycle
// unless back pressure holds it; stages close bubbles, so input is taken while
// a result waits. Its depth is set by the calibration multipliers, second-order
// squares and the 24x40 pressure product split into two halves. The user must
// write calibration words through the cfg port only while no beat is in flight;
// the block does not enforce this. Indexes past the sixth word are dropped.
// Depends on bptc_pkg, bptc_front, bptc_corr, bptc_press and the macros header.
`default_nettype none
`include "baro_pressure_temp_compensation_macros.svh"

module baro_pressure_temp_compensation (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // raw_pressure[23:0], raw_temperature[47:24]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata    // pressure_out[31:0], temperature_out[51:32], zero
);

  bptc_pkg::cal_t   cal;
  bptc_pkg::front_t front_data;
  bptc_pkg::corr_t  corr_data;
  logic             front_valid, front_ready;
  logic             corr_valid, corr_ready;
  logic [31:0]      pressure;
  logic [19:0]      temperature;

  logic [3:0]       inflight, inflight_next;
  logic             in_beat, out_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bptc_pkg::REG_PRESSURE_SENSITIVITY:   cal.pressure_sensitivity   <= cfg_data;
        bptc_pkg::REG_PRESSURE_OFFSET:        cal.pressure_offset        <= cfg_data;
        bptc_pkg::REG_SENSITIVITY_TEMP_COEFF: cal.sensitivity_temp_coeff <= cfg_data;
        bptc_pkg::REG_OFFSET_TEMP_COEFF:      cal.offset_temp_coeff      <= cfg_data;
        bptc_pkg::REG_REFERENCE_TEMPERATURE:  cal.reference_temperature  <= cfg_data;
        bptc_pkg::REG_TEMPERATURE_COEFF:      cal.temperature_coeff      <= cfg_data;
        default: ;
      endcase
    end
  end

  bptc_front u_front (
    .clk                (clk),
    .rst                (rst),
    .cal                (cal),
    .in_valid           (s_tvalid),
    .in_ready           (s_tready),
    .in_raw_pressure    (s_tdata[23:0]),
    .in_raw_temperature (s_tdata[47:24]),
    .out_valid          (front_valid),
    .out_ready          (front_ready),
    .out_data           (front_data)
  );

  bptc_corr u_corr (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (corr_valid),
    .out_ready (corr_ready),
    .out_data  (corr_data)
  );

  bptc_press u_press (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (corr_valid),
    .in_ready        (corr_ready),
    .in_data         (corr_data),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_pressure    (pressure),
    .out_temperature (temperature)
  );

  assign m_tdata = {4'h0, temperature, pressure};

  // beats in flight, for the checks below
  assign in_beat  = s_tvalid && s_tready;
  assign out_beat = m_tvalid && m_tready;

  always_comb begin
    unique case ({in_beat, out_beat})
      2'b10:   inflight_next = inflight + 4'd1;
      2'b01:   inflight_next = inflight - 4'd1;
      default: inflight_next = inflight;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  `BPTC_ASSERT_IMP(a_no_phantom_result, clk, rst, m_tvalid, inflight != 4'd0, "result with no beat in flight")
  `BPTC_ASSERT_IMP(a_depth_bound, clk, rst, 1'b1, inflight <= 4'(bptc_pkg::PIPE_DEPTH), "more beats in flight than stages")
  `BPTC_ASSERT_IMP(a_empty_takes_input, clk, rst, inflight == 4'd0, s_tready, "empty pipeline refuses input")

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking bench for baro_pressure_temp_compensation: drives raw reading pairs
// under several calibration sets and compares every result against a local model.
// Depends on bptc_pkg and the block's RTL only.
module testbench;

  localparam logic [bptc_pkg::IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [bptc_pkg::IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 3 * bptc_pkg::PIPE_DEPTH;

  typedef struct {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
    logic signed [31:0] pressure;
    logic signed [19:0] temperature;
  } comp_reading_t;

  class compensation_checker;
    logic [bptc_pkg::CAL_W-1:0] cal_word [6];
    comp_reading_t expected_readings [$];
    int errors;

    function new();
      foreach (cal_word[i]) cal_word[i] = '0;
      errors = 0;
    endfunction

    function void set_cal(logic [bptc_pkg::IDX_W-1:0] idx, logic [bptc_pkg::CAL_W-1:0] val);
      // indexes past the sixth word are dropped by the block
      if (idx <= bptc_pkg::REG_TEMPERATURE_COEFF) cal_word[idx] = val;
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    task note_error(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    // Second-order compensation in 64-bit signed arithmetic, floor shifts.
    function comp_reading_t compensate(logic [23:0] raw_p, logic [23:0] raw_t);
      longint d1, d2, c1, c2, c3, c4, c5, c6;
      longint dt, off, sens, temp, sq, pres;
      comp_reading_t r;
      d1 = {40'd0, raw_p};
      d2 = {40'd0, raw_t};
      c1 = {48'd0, cal_word[bptc_pkg::REG_PRESSURE_SENSITIVITY]};
      c2 = {48'd0, cal_word[bptc_pkg::REG_PRESSURE_OFFSET]};
      c3 = {48'd0, cal_word[bptc_pkg::REG_SENSITIVITY_TEMP_COEFF]};
      c4 = {48'd0, cal_word[bptc_pkg::REG_OFFSET_TEMP_COEFF]};
      c5 = {48'd0, cal_word[bptc_pkg::REG_REFERENCE_TEMPERATURE]};
      c6 = {48'd0, cal_word[bptc_pkg::REG_TEMPERATURE_COEFF]};
      dt = d2 - c5 * 256;
      off = c2 * 65536 + ((c4 * dt) >>> 7);
      sens = c1 * 32768 + ((c3 * dt) >>> 8);
      temp = 2000 + ((dt * c6) >>> 23);
      if (temp < 2000) begin
        sq = 5 * (temp - 2000) * (temp - 2000);
        off -= sq >>> 1;
        sens -= sq >>> 2;
        if (temp < -1500) begin
          sq = (temp + 1500) * (temp + 1500);
          off -= 7 * sq;
          sens -= (11 * sq) >>> 1;
        end
        temp -= (dt * dt) >>> 31;
      end
      pres = (((d1 * sens) >>> 21) - off) >>> 15;
      r.raw_pressure = raw_p;
      r.raw_temperature = raw_t;
      r.pressure = pres[31:0];
      r.temperature = temp[19:0];
      return r;
    endfunction

    function void note_reading(logic [23:0] raw_p, logic [23:0] raw_t);
      expected_readings.push_back(compensate(raw_p, raw_t));
    endfunction

    task check_result(logic [31:0] pressure, logic [19:0] temperature);
      comp_reading_t e;
      if (expected_readings.size() == 0) begin
        note_error($sformatf("result p=%0d t=%0d with no reading pending",
                             $signed(pressure), $signed(temperature)));
        return;
      end
      e = expected_readings.pop_front();
      if (pressure !== e.pressure)
        note_error($sformatf("D1=%0d D2=%0d pressure got %0d want %0d", e.raw_pressure,
                             e.raw_temperature, $signed(pressure), e.pressure));
      if (temperature !== e.temperature)
        note_error($sformatf("D1=%0d D2=%0d temperature got %0d want %0d", e.raw_pressure,
                             e.raw_temperature, $signed(temperature), e.temperature));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;   // raw_pressure[23:0], raw_temperature[47:24]
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [55:0] m_tdata;        // pressure_out[31:0], temperature_out[51:32], zero

  compensation_checker sb = new();
  bit sink_hold = 1'b0;
  int burst_left = 0;
  int cycle_count = 0;

  baro_pressure_temp_compensation dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL baro_pressure_temp_compensation");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata[31:0], m_tdata[51:32]);
  end

  // Sink: random runs of ready patterns, plus one long hold-off on request.
  initial begin
    int mode;
    int run;
    forever begin
      if (sink_hold) begin
        m_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        run = $urandom_range(5, 60);
        repeat (run) begin
          case (mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 4) == 0);
            default: m_tready <= ($urandom_range(0, 4) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic write_cal(input logic [bptc_pkg::IDX_W-1:0] idx,
                           input logic [bptc_pkg::CAL_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_cal(idx, val);
  endtask

  task automatic load_cal(input logic [15:0] c1, c2, c3, c4, c5, c6, input bit with_spares);
    write_cal(bptc_pkg::REG_PRESSURE_SENSITIVITY, c1);
    write_cal(bptc_pkg::REG_PRESSURE_OFFSET, c2);
    write_cal(bptc_pkg::REG_SENSITIVITY_TEMP_COEFF, c3);
    write_cal(bptc_pkg::REG_OFFSET_TEMP_COEFF, c4);
    write_cal(bptc_pkg::REG_REFERENCE_TEMPERATURE, c5);
    write_cal(bptc_pkg::REG_TEMPERATURE_COEFF, c6);
    if (with_spares) begin
      write_cal(CFG_SPARE_LO, 16'($urandom_range(0, 65535)));
      write_cal(CFG_SPARE_HI, 16'($urandom_range(0, 65535)));
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Offer one beat and hold it until accepted.
  task automatic push_reading(input logic [23:0] raw_p, input logic [23:0] raw_t);
    s_tvalid <= 1'b1;
    s_tdata <= {raw_t, raw_p};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_reading(raw_p, raw_t);
  endtask

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
  endtask

  function automatic logic [23:0] pick_pressure();
    case ($urandom_range(0, 7))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return 24'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  // Spread temperature readings over warm, near-reference and cold regions.
  function automatic logic [23:0] pick_temperature();
    int ref_t;
    int t;
    ref_t = int'(sb.cal_word[bptc_pkg::REG_REFERENCE_TEMPERATURE]) * 256;
    case ($urandom_range(0, 3))
      0: t = ref_t + int'($urandom_range(0, 8192)) - 4096;
      1: t = ref_t - int'($urandom_range(0, ref_t));
      default: t = $urandom_range(0, 24'hFFFFFF);
    endcase
    if (t < 0) t = 0;
    if (t > 16777215) t = 16777215;
    return t[23:0];
  endfunction

  task automatic send_random(input int count);
    logic [23:0] raw_p;
    logic [23:0] raw_t;
    for (int i = 0; i < count; i++) begin
      raw_p = pick_pressure();
      raw_t = pick_temperature();
      push_reading(raw_p, raw_t);
      pace_sender();
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // calibration left at reset: all words zero
    push_reading(24'h000000, 24'h000000);
    push_reading(24'hFFFFFF, 24'hFFFFFF);
    push_reading(24'hFFFFFF, 24'h000000);
    push_reading(24'h000000, 24'hFFFFFF);
    send_random(150);
    drain_results();

    // reference at 2^23 and unit slope: hit the 20 degC and -15 degC thresholds exactly
    load_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'h8000, 16'h8000, 1'b0);
    push_reading(24'h800000, 24'd8388608);
    push_reading(24'h800000, 24'd8388607);
    push_reading(24'hFFFFFF, 24'd8388607);
    push_reading(24'h800000, 24'd7492608);
    push_reading(24'h800000, 24'd7492607);
    push_reading(24'hFFFFFF, 24'd7492607);
    push_reading(24'h000000, 24'd7492607);
    push_reading(24'hFFFFFF, 24'h000000);
    push_reading(24'hFFFFFF, 24'hFFFFFF);
    send_random(250);
    drain_results();

    // typical calibration; long sink hold-off while the source keeps offering
    load_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312, 1'b1);
    sink_hold = 1'b1;
    burst_left = 200;
    send_random(300);
    drain_results();

    load_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    push_reading(24'h000000, 24'h000000);
    push_reading(24'hFFFFFF, 24'h000000);
    push_reading(24'hFFFFFF, 24'hFFFFFF);
    send_random(250);
    drain_results();

    // deepest cold corner: high reference, steep slope
    load_cal(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1);
    send_random(250);
    drain_results();

    repeat (2) begin
      load_cal(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               1'b1);
      send_random(250);
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS baro_pressure_temp_compensation");
    end else begin
      $display("FAIL baro_pressure_temp_compensation");
    end
    $finish;
  end
endmodule
